// ===== src/radiotap_header_field_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Radiotap header parser assertion macros
// Concurrent assertion wrappers; they reduce to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RADIOTAP_HEADER_FIELD_PARSER_ASSERT_SVH
`define RADIOTAP_HEADER_FIELD_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Invariant that holds at every clock edge out of reset
`define RHFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rhfp invariant violated");

// Same-cycle implication
`define RHFP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rhfp implication violated");

// Next-cycle implication
`define RHFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rhfp next-cycle implication violated");

`else

`define RHFP_ASSERT(lbl, clk, rstn, prop)
`define RHFP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RHFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/rhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radiotap header parser package
// Shared types, byte role and status codes, and the field size table.
// ----------------------------------------------------------------------------
package rhfp_pkg;

  // Number of known fields and the "no field" marker
  localparam int unsigned NUM_KNOWN = 18;
  localparam logic [4:0] NO_FIELD = 5'd18;

  // Default depth of the queue between front and back
  localparam int unsigned RHFP_QUEUE_DEPTH = 2;

  // Saturation value of the byte offset
  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  // Per field: alignment in the upper nibble, length in the lower nibble
  localparam logic [7:0] SIZE_TABLE [NUM_KNOWN] = '{
    8'h88, 8'h11, 8'h11, 8'h24, 8'h22, 8'h11, 8'h11, 8'h22, 8'h22,
    8'h22, 8'h11, 8'h11, 8'h11, 8'h11, 8'h22, 8'h22, 8'h11, 8'h11
  };

  typedef enum logic [2:0] {
    ROLE_FIXED  = 3'd0,
    ROLE_EXT    = 3'd1,
    ROLE_PAD    = 3'd2,
    ROLE_FIELD  = 3'd3,
    ROLE_TAIL   = 3'd4,
    ROLE_BEYOND = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_LEN_OVER    = 3'd2,
    ST_BITMAP_OVR  = 3'd3,
    ST_FIELD_OVR   = 3'd4
  } status_e;

  // One classified input byte as it travels through the queue
  typedef struct packed {
    logic [7:0]  data;
    logic        sh;
    logic [15:0] lim;
    logic [15:0] offset;
  } item_t;

endpackage

// ===== src/radiotap_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// Radiotap header field parser
// Labels each byte of a radiotap header stream with its role and field.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle and returns one labeled result per
// byte, in order. A byte is accepted every cycle while the queue has room; the
// sustained rate is one byte per clock while the output takes results, set by
// the parse step of the back end (field selection is a priority pick over the
// present bits plus one add and compare against the header length). A result
// passes through the queue and then the output register before it can
// transfer. With the output stalled, the queue takes up to QueueDepth more
// bytes before input ready drops.
module radiotap_header_field_parser
  import rhfp_pkg::*;
#(
  parameter int unsigned QueueDepth = RHFP_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_header_i,
  input  logic [15:0] limit_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  byte_role_o,
  output logic [4:0]  field_index_o,
  output logic [2:0]  byte_in_field_o,
  output logic        field_end_o,
  output logic [2:0]  parse_status_o,
  output logic        header_done_o
);

  logic  q_ready;
  logic  q_valid;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  rhfp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .start_of_header_i (start_of_header_i),
    .limit_len_i       (limit_len_i),
    .q_ready_i         (q_ready),
    .push_o            (push),
    .push_item_o       (push_item)
  );

  rhfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .item_o      (pop_item)
  );

  rhfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_out_o      (byte_out_o),
    .byte_role_o     (byte_role_o),
    .field_index_o   (field_index_o),
    .byte_in_field_o (byte_in_field_o),
    .field_end_o     (field_end_o),
    .parse_status_o  (parse_status_o),
    .header_done_o   (header_done_o)
  );

endmodule

// ===== src/rhfp_queue.sv =====
// ----------------------------------------------------------------------------
// Radiotap header parser item queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rhfp_queue
  import rhfp_pkg::*;
#(
  parameter int unsigned Depth = RHFP_QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  ready_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

`include "radiotap_header_field_parser_assert.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `RHFP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FullCnt)
  `RHFP_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, ready_o)
  `RHFP_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o)

endmodule

// ===== src/rhfp_front.sv =====
// ----------------------------------------------------------------------------
// Radiotap header parser front end
// Accepts input bytes, tracks the header-relative offset and queues them.
// ----------------------------------------------------------------------------
module rhfp_front
  import rhfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_header_i,
  input  logic [15:0] limit_len_i,
  input  logic        q_ready_i,
  output logic        push_o,
  output item_t       push_item_o
);

  logic [15:0] off_q, off_d;
  logic [15:0] cur_off;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  // Restart offset on a header start, saturate at the top
  always_comb begin
    cur_off = start_of_header_i ? 16'd0 : off_q;
    off_d   = off_q;
    if (push_o) begin
      off_d = (cur_off != OFFSET_MAX) ? cur_off + 16'd1 : cur_off;
    end
  end

  always_comb begin
    push_item_o.data   = data_byte_i;
    push_item_o.sh     = start_of_header_i;
    push_item_o.lim    = limit_len_i;
    push_item_o.offset = cur_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
    end else begin
      off_q <= off_d;
    end
  end

endmodule

// ===== src/rhfp_back.sv =====
// ----------------------------------------------------------------------------
// Radiotap header parser back end
// Labels each queued byte, walks present fields and registers the result.
// ----------------------------------------------------------------------------
module rhfp_back
  import rhfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  byte_role_o,
  output logic [4:0]  field_index_o,
  output logic [2:0]  byte_in_field_o,
  output logic        field_end_o,
  output logic [2:0]  parse_status_o,
  output logic        header_done_o
);

`include "radiotap_header_field_parser_assert.svh"

  // Offsets within the fixed header
  localparam logic [2:0] OfsVersion = 3'd0;
  localparam logic [2:0] OfsPad     = 3'd1;
  localparam logic [2:0] OfsLenLo   = 3'd2;
  localparam logic [2:0] OfsLenHi   = 3'd3;
  localparam logic [2:0] OfsPres0   = 3'd4;
  localparam logic [2:0] OfsPres1   = 3'd5;
  localparam logic [2:0] OfsPres2   = 3'd6;
  localparam logic [2:0] OfsPres3   = 3'd7;

  typedef struct packed {
    logic [2:0]  pad;
    logic [3:0]  fbl;
    logic [4:0]  cf;
    logic [17:0] pb;
    status_e     err;
  } place_t;

  // Pick the lowest present field and size it at offset arg
  function automatic place_t place_next(logic [17:0] pb, logic [15:0] hl,
                                        logic [15:0] arg, status_e err);
    place_t     r;
    logic [4:0] f;
    logic       found;
    logic [7:0] ent;
    logic [3:0] align;
    logic [3:0] size;
    logic [3:0] mis;
    logic [3:0] pad;
    logic [16:0] fend;
    r.pad = '0;
    r.fbl = '0;
    r.cf  = NO_FIELD;
    r.pb  = pb;
    r.err = err;
    f     = '0;
    found = 1'b0;
    for (int i = NUM_KNOWN - 1; i >= 0; i--) begin
      if (pb[i]) begin
        f     = 5'(i);
        found = 1'b1;
      end
    end
    ent   = SIZE_TABLE[f];
    align = ent[7:4];
    size  = ent[3:0];
    mis   = arg[3:0] & (align - 4'd1);
    pad   = (mis != 4'd0) ? align - mis : 4'd0;
    fend  = {1'b0, arg} + {13'd0, pad} + {13'd0, size};
    if (found) begin
      if (fend > {1'b0, hl}) begin
        if (err == ST_OK) begin
          r.err = ST_FIELD_OVR;
        end
        r.pb = '0;
      end else begin
        r.pad   = pad[2:0];
        r.fbl   = size;
        r.cf    = f;
        r.pb[f] = 1'b0;
      end
    end
    return r;
  endfunction

  // Parse state
  logic [15:0] hl_q, hl_d;
  logic [15:0] av_q, av_d;
  logic [17:0] pb_q, pb_d;
  logic        ext_q, ext_d;
  logic [4:0]  cf_q, cf_d;
  logic [3:0]  fbl_q, fbl_d;
  logic [2:0]  pad_q, pad_d;
  status_e     err_q, err_d;

  // Output register
  logic        out_valid_q;
  logic [7:0]  data_q;
  role_e       role_q, role_d;
  logic [4:0]  fi_q, fi_d;
  logic [2:0]  bif_q, bif_d;
  logic        fe_q, fe_d;
  logic        done_q, done_d;

  logic [7:0]  d;
  logic [15:0] o;
  logic        do_place;
  logic [15:0] place_arg;
  logic [4:0]  cf_sel;
  logic [3:0]  fsize;
  logic [3:0]  bif_full;
  place_t      pr;

  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign d     = item_i.data;
  assign o     = item_i.offset;

  // Label the byte and step the parse state
  always_comb begin
    hl_d      = hl_q;
    av_d      = av_q;
    pb_d      = pb_q;
    ext_d     = ext_q;
    cf_d      = cf_q;
    fbl_d     = fbl_q;
    pad_d     = pad_q;
    err_d     = err_q;
    role_d    = ROLE_FIXED;
    fi_d      = NO_FIELD;
    bif_d     = '0;
    fe_d      = 1'b0;
    do_place  = 1'b0;
    place_arg = 16'd8;
    cf_sel    = (cf_q < NO_FIELD) ? cf_q : 5'd0;
    fsize     = SIZE_TABLE[cf_sel][3:0];
    bif_full  = fsize - fbl_q;
    pr        = '0;

    if (item_i.sh) begin
      hl_d  = '0;
      pb_d  = '0;
      ext_d = 1'b0;
      cf_d  = NO_FIELD;
      fbl_d = '0;
      pad_d = '0;
      err_d = ST_OK;
      av_d  = item_i.lim;
      fsize    = SIZE_TABLE[0][3:0];
      bif_full = fsize;
    end

    if (o < 16'd8) begin
      role_d = ROLE_FIXED;
      unique case (o[2:0])
        OfsVersion: begin
          if (d != 8'd0 && err_d == ST_OK) begin
            err_d = ST_BAD_VERSION;
          end
        end
        OfsPad: ;
        OfsLenLo: hl_d[7:0] = d;
        OfsLenHi: begin
          hl_d[15:8] = d;
          if (err_d == ST_OK && av_d < hl_d) begin
            err_d = ST_LEN_OVER;
          end
        end
        OfsPres0: pb_d = {10'd0, d};
        OfsPres1: pb_d[15:8] = pb_d[15:8] | d;
        OfsPres2: pb_d[17:16] = pb_d[17:16] | d[1:0];
        OfsPres3: begin
          ext_d = d[7];
          if (err_d == ST_OK && !d[7]) begin
            do_place  = 1'b1;
            place_arg = 16'd8;
          end
        end
        default: ;
      endcase
    end else if (o == OFFSET_MAX) begin
      role_d = ROLE_BEYOND;
    end else if (err_d != ST_OK) begin
      role_d = (o < hl_d) ? ROLE_TAIL : ROLE_BEYOND;
    end else begin
      if (ext_d) begin
        // Walk extension present words
        role_d = ROLE_EXT;
        if (o[1:0] == 2'd3) begin
          if (d[7]) begin
            if ({1'b0, o} + 17'd1 > {1'b0, hl_d}) begin
              err_d = ST_BITMAP_OVR;
              ext_d = 1'b0;
            end
          end else begin
            ext_d     = 1'b0;
            do_place  = 1'b1;
            place_arg = o + 16'd1;
          end
        end
      end else if (pad_d != 3'd0) begin
        role_d = ROLE_PAD;
        pad_d  = pad_d - 3'd1;
      end else if (fbl_d != 4'd0) begin
        role_d = ROLE_FIELD;
        fi_d   = cf_d;
        bif_d  = bif_full[2:0];
        fbl_d  = fbl_d - 4'd1;
        if (fbl_d == 4'd0) begin
          fe_d      = 1'b1;
          do_place  = 1'b1;
          place_arg = o + 16'd1;
        end
      end else begin
        role_d = ROLE_TAIL;
      end
      if (o >= hl_d) begin
        role_d = ROLE_BEYOND;
        fi_d   = NO_FIELD;
        bif_d  = '0;
        fe_d   = 1'b0;
      end
    end

    // Place the next present field once per byte
    if (do_place) begin
      pr    = place_next(pb_d, hl_d, place_arg, err_d);
      pad_d = pr.pad;
      fbl_d = pr.fbl;
      cf_d  = pr.cf;
      pb_d  = pr.pb;
      err_d = pr.err;
    end

    done_d = (o >= 16'd3) && ({1'b0, o} + 17'd1 == {1'b0, hl_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q        <= '0;
      av_q        <= '0;
      pb_q        <= '0;
      ext_q       <= 1'b0;
      cf_q        <= NO_FIELD;
      fbl_q       <= '0;
      pad_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        hl_q  <= hl_d;
        av_q  <= av_d;
        pb_q  <= pb_d;
        ext_q <= ext_d;
        cf_q  <= cf_d;
        fbl_q <= fbl_d;
        pad_q <= pad_d;
        err_q <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until transfer
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= d;
      role_q <= role_d;
      fi_q   <= fi_d;
      bif_q  <= bif_d;
      fe_q   <= fe_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_out_o      = data_q;
  assign byte_role_o     = role_q;
  assign field_index_o   = fi_q;
  assign byte_in_field_o = bif_q;
  assign field_end_o     = fe_q;
  assign parse_status_o  = err_q;
  assign header_done_o   = done_q;

  `RHFP_ASSERT_NEXT(a_err_sticky, clk_i, rst_ni,
                    pop_o && !item_i.sh && err_q != ST_OK, err_q == $past(err_q))
  `RHFP_ASSERT_IMPL(a_end_is_content, clk_i, rst_ni,
                    out_valid_q && fe_q, role_q == ROLE_FIELD)
  `RHFP_ASSERT(a_fbl_bound, clk_i, rst_ni, fbl_q <= 4'd8)
  `RHFP_ASSERT_NEXT(a_state_hold, clk_i, rst_ni,
                    !pop_o, $stable(hl_q) && $stable(pb_q) && $stable(err_q))

endmodule

// ===== tb/tb_radiotap_header_field_parser.sv =====
// ----------------------------------------------------------------------------
// Radiotap header field parser testbench
// Streams directed and random radiotap headers through the parser, labels
// every accepted byte with a local tracker of the parse state, and compares
// each labeled result against the oldest pending label, under random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_radiotap_header_field_parser;
  import rhfp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned STALL_CYCLES   = 64;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_BYTES   = 650;

  // One input byte with its sideband
  typedef struct {
    logic [7:0]  data;
    logic        sos;
    logic [15:0] lim;
  } hdr_byte_t;

  // The label the parser gives one byte
  typedef struct {
    logic [7:0] byte_out;
    role_e      role;
    logic [4:0] field;
    logic [2:0] pos;
    logic       fend;
    status_e    status;
    logic       done;
  } byte_label_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data   = 8'h00;
  logic        in_sos    = 1'b0;
  logic [15:0] in_lim    = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_out;
  logic [2:0]  byte_role;
  logic [4:0]  field_index;
  logic [2:0]  byte_in_field;
  logic        field_end;
  logic [2:0]  parse_status;
  logic        header_done;

  hdr_byte_t   tx_byte_q[$];
  byte_label_t label_q[$];
  hdr_byte_t   drv_byte;
  byte_label_t mon_label;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stim_count    = 0;
  int unsigned err_count     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_count   = 0;
  logic        stall_armed   = 1'b0;
  logic        stall_done    = 1'b0;

  // Tracked parse state
  logic [15:0] trk_offset;
  logic [15:0] trk_hdr_len;
  logic [15:0] trk_avail;
  logic [17:0] trk_present;
  logic        trk_ext;
  logic [4:0]  trk_field;
  logic [3:0]  trk_field_left;
  logic [2:0]  trk_pad_left;
  status_e     trk_err;

  radiotap_header_field_parser DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (in_data),
    .start_of_header_i (in_sos),
    .limit_len_i       (in_lim),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .byte_out_o        (byte_out),
    .byte_role_o       (byte_role),
    .field_index_o     (field_index),
    .byte_in_field_o   (byte_in_field),
    .field_end_o       (field_end),
    .parse_status_o    (parse_status),
    .header_done_o     (header_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clear everything a new header resets
  function automatic void clear_header();
    trk_offset     = '0;
    trk_hdr_len    = '0;
    trk_present    = '0;
    trk_ext        = 1'b0;
    trk_field      = NO_FIELD;
    trk_field_left = '0;
    trk_pad_left   = '0;
    trk_err        = ST_OK;
  endfunction

  // Place the lowest present field at header offset 'at', padding first
  function automatic void place_field(input int unsigned at);
    int unsigned i, f, align, len, mis, pad;
    f = NUM_KNOWN;
    for (i = NUM_KNOWN; i > 0; i--) begin
      if (trk_present[i-1]) f = i - 1;
    end
    trk_pad_left   = '0;
    trk_field_left = '0;
    trk_field      = NO_FIELD;
    if (f < NUM_KNOWN) begin
      align = SIZE_TABLE[f][7:4];
      len   = SIZE_TABLE[f][3:0];
      mis   = at & (align - 1);
      pad   = (mis != 0) ? align - mis : 0;
      if (at + pad + len > trk_hdr_len) begin
        if (trk_err == ST_OK) trk_err = ST_FIELD_OVR;
        trk_present = '0;
      end else begin
        trk_pad_left   = 3'(pad);
        trk_field_left = 4'(len);
        trk_field      = 5'(f);
        trk_present[f] = 1'b0;
      end
    end
  endfunction

  // Advance the tracked state by one byte and return its label
  function automatic byte_label_t label_byte(input hdr_byte_t b);
    byte_label_t r;
    int unsigned o, cf, len;
    if (b.sos) begin
      clear_header();
      trk_avail = b.lim;
    end
    o          = trk_offset;
    r.byte_out = b.data;
    r.role     = ROLE_FIXED;
    r.field    = NO_FIELD;
    r.pos      = '0;
    r.fend     = 1'b0;
    if (o < 8) begin
      case (o)
        0: if (b.data != 8'h00 && trk_err == ST_OK) trk_err = ST_BAD_VERSION;
        2: trk_hdr_len[7:0] = b.data;
        3: begin
          trk_hdr_len[15:8] = b.data;
          if (trk_err == ST_OK && trk_avail < trk_hdr_len) trk_err = ST_LEN_OVER;
        end
        4: trk_present = {10'h000, b.data};
        5: trk_present[15:8] = trk_present[15:8] | b.data;
        6: trk_present[17:16] = trk_present[17:16] | b.data[1:0];
        7: begin
          trk_ext = b.data[7];
          if (trk_err == ST_OK && !trk_ext) place_field(8);
        end
        default: ;
      endcase
    end else if (o == OFFSET_MAX) begin
      r.role = ROLE_BEYOND;
    end else if (trk_err != ST_OK) begin
      r.role = (o < trk_hdr_len) ? ROLE_TAIL : ROLE_BEYOND;
    end else begin
      if (trk_ext) begin
        r.role = ROLE_EXT;
        // Last byte of a chained present word: check or end the chain
        if ((o & 3) == 3) begin
          if (b.data[7]) begin
            if (o + 1 > trk_hdr_len) begin
              trk_err = ST_BITMAP_OVR;
              trk_ext = 1'b0;
            end
          end else begin
            trk_ext = 1'b0;
            place_field(o + 1);
          end
        end
      end else if (trk_pad_left != 0) begin
        r.role = ROLE_PAD;
        trk_pad_left--;
      end else if (trk_field_left != 0) begin
        cf      = (trk_field < NUM_KNOWN) ? trk_field : 0;
        len     = SIZE_TABLE[cf][3:0];
        r.role  = ROLE_FIELD;
        r.field = trk_field;
        r.pos   = 3'(len - trk_field_left);
        trk_field_left--;
        if (trk_field_left == 0) begin
          r.fend = 1'b1;
          place_field(o + 1);
        end
      end else begin
        r.role = ROLE_TAIL;
      end
      if (o >= trk_hdr_len) begin
        r.role  = ROLE_BEYOND;
        r.field = NO_FIELD;
        r.pos   = '0;
        r.fend  = 1'b0;
      end
    end
    r.done = (o >= 3 && o + 1 == trk_hdr_len);
    if (o < OFFSET_MAX) trk_offset = 16'(o + 1);
    r.status = trk_err;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Driver: label each transfer, then offer the next pending byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) label_q.push_back(label_byte(drv_byte));
      if (!in_valid || in_ready) begin
        if (tx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_byte = tx_byte_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= drv_byte.data;
          in_sos   <= drv_byte.sos;
          in_lim   <= drv_byte.lim;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (label_q.size() == 0) begin
          $error("result with no pending label: byte_out 0x%0h", byte_out);
          err_count++;
        end else begin
          mon_label = label_q.pop_front();
          check_field("byte_out", 16'(mon_label.byte_out), 16'(byte_out));
          check_field("byte_role", 16'(mon_label.role), 16'(byte_role));
          check_field("field_index", 16'(mon_label.field), 16'(field_index));
          check_field("byte_in_field", 16'(mon_label.pos), 16'(byte_in_field));
          check_field("field_end", 16'(mon_label.fend), 16'(field_end));
          check_field("parse_status", 16'(mon_label.status), 16'(parse_status));
          check_field("header_done", 16'(mon_label.done), 16'(header_done));
        end
      end
      // Hold off for a long stretch once, so the block backs up
      if (stall_armed && !stall_done) begin
        out_ready <= 1'b0;
        if (stall_count == STALL_CYCLES) stall_done <= 1'b1;
        else stall_count <= stall_count + 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic push_byte(input logic [7:0] data, input logic sos, input logic [15:0] lim);
    hdr_byte_t b;
    b.data = data;
    b.sos  = sos;
    b.lim  = lim;
    tx_byte_q.push_back(b);
    stim_count++;
  endtask

  // Push a header prefix followed by random bytes up to n_bytes
  task automatic push_stream(ref logic [7:0] pre[$], input int unsigned n_bytes,
                             input logic sos, input logic [15:0] lim);
    int unsigned i;
    for (i = 0; i < n_bytes; i++) begin
      push_byte((i < pre.size()) ? pre[i] : 8'($urandom), (i == 0) ? sos : 1'b0,
                (i == 0) ? lim : 16'($urandom));
    end
  endtask

  // One header: mostly well formed, otherwise noise or a broken stream
  task automatic gen_header();
    logic [7:0]  pre[$];
    logic [63:0] fixed;
    logic [31:0] pres, word;
    logic [15:0] hlen, lim;
    int unsigned n_ext, n_bytes, i;
    if ($urandom_range(99) < 78) begin
      case ($urandom_range(9))
        0: hlen = 16'($urandom);
        1: hlen = 16'($urandom_range(0, 7));
        default: hlen = 16'($urandom_range(8, 64));
      endcase
      case ($urandom_range(9))
        0: lim = 16'($urandom);
        1: lim = (hlen == 0) ? 16'h0000 : 16'($urandom_range(0, hlen - 1));
        default: lim = (hlen > 16'hFF00) ? 16'hFFFF : 16'(hlen + $urandom_range(0, 255));
      endcase
      case ($urandom_range(3))
        0: pres = $urandom;
        1: pres = $urandom & $urandom;
        2: pres = 32'h1 << $urandom_range(0, 17);
        default: pres = $urandom | 32'h0003_FFFF;
      endcase
      n_ext    = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      pres[31] = (n_ext != 0);
      fixed    = {pres, hlen, 8'($urandom), 8'h00};
      for (i = 0; i < 8; i++) pre.push_back(fixed[8*i +: 8]);
      // Chained present words: bit 31 set on all but the last
      for (i = 0; i < n_ext; i++) begin
        word     = $urandom;
        word[31] = (i + 1 < n_ext);
        pre.push_back(word[7:0]);
        pre.push_back(word[15:8]);
        pre.push_back(word[23:16]);
        pre.push_back(word[31:24]);
      end
      n_bytes = (hlen > 72) ? 72 : hlen;
      if (n_bytes < pre.size()) n_bytes = pre.size();
      n_bytes += $urandom_range(0, 4);
      push_stream(pre, n_bytes, 1'b1, lim);
    end else begin
      fixed = {$urandom, 16'($urandom_range(0, 40)), 8'($urandom), 8'($urandom)};
      if ($urandom_range(1) == 0) fixed[7:0] = 8'h00;
      for (i = 0; i < 8; i++) pre.push_back(fixed[8*i +: 8]);
      push_stream(pre, $urandom_range(1, 24), ($urandom_range(99) < 85), 16'($urandom));
    end
  endtask

  task automatic gen_random(input int unsigned n_items);
    int unsigned target;
    target = stim_count + n_items;
    while (stim_count < target) gen_header();
  endtask

  task automatic gen_directed();
    logic [7:0] pre[$];
    // Bytes before any start of header: available length is zero
    pre = {};
    pre.push_back(8'h00); pre.push_back(8'hAA); pre.push_back(8'h10);
    pre.push_back(8'h00); pre.push_back(8'h5A);
    push_stream(pre, 5, 1'b0, 16'h0000);
    // Bad version with every present bit set, header shorter than the stream
    pre = {};
    pre.push_back(8'hFF); pre.push_back(8'h00); pre.push_back(8'h09);
    pre.push_back(8'h00);
    repeat (4) pre.push_back(8'hFF);
    pre.push_back(8'h11); pre.push_back(8'h22);
    push_stream(pre, 10, 1'b1, 16'hFFFF);
    // First field does not fit in an 8 byte header
    pre = {};
    pre.push_back(8'h00); pre.push_back(8'h00); pre.push_back(8'h08);
    pre.push_back(8'h00); pre.push_back(8'h01);
    repeat (3) pre.push_back(8'h00);
    pre.push_back(8'h33);
    push_stream(pre, 9, 1'b1, 16'h0008);
  endtask

  // Hold the sender until every label has come back
  task automatic wait_drained();
    @(negedge clk);
    while (tx_byte_q.size() != 0 || in_valid || label_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    // Tracker starts from the reset state
    clear_header();
    trk_avail = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 82;
    gen_directed();
    gen_random(RANDOM_BYTES);
    wait_drained();

    send_idle_pct = 82;
    recv_idle_pct = 35;
    gen_random(RANDOM_BYTES);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_armed   = 1'b1;
    gen_random(RANDOM_BYTES);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && label_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
